### design/sps_pkg.sv
// Shared types, constants and helpers for the stepper phase sequencer.
`default_nettype none
package sps_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned PeriodWidth = 26;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned ProdWidth   = 31;

  localparam logic [PeriodWidth-1:0] US_PER_MINUTE = 26'd60000000;
  localparam logic [PeriodWidth-1:0] SLOW_PERIOD   = 26'd4000;
  localparam logic [PeriodWidth-1:0] FAST_PERIOD   = 26'd1500;
  localparam logic [15:0]            PCT_FULL      = 16'd100;
  localparam int unsigned            PctStep       = (4000 - 1500) / 100;

  localparam logic [CfgWidth-1:0] STEPS_PER_REV_RST  = 16'd2048;
  localparam logic [CfgWidth-1:0] TICK_INCREMENT_RST = 16'd500;

  localparam int unsigned DivSteps   = PeriodWidth;
  localparam int unsigned CountWidth = $clog2(DivSteps);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RPM  = 2'd1,
    OP_PCT  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic {
    REG_STEPS_PER_REV  = 1'b0,
    REG_TICK_INCREMENT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic capture;
    logic tick_add;
    logic tick_sub;
    logic set_dir;
    logic set_pct;
    logic mul;
    logic div_init;
    logic div_step;
    logic period_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic rpm_skip;
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic [3:0] coil_of(input logic [1:0] ph);
    logic [3:0] pat;
    unique case (ph)
      2'd0: pat = 4'h3;
      2'd1: pat = 4'h6;
      2'd2: pat = 4'hC;
      2'd3: pat = 4'h9;
      default: pat = 4'h3;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

### design/sps_ifs.sv
// Valid/ready channel interfaces for command words and result words.
`default_nettype none
interface sps_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [15:0] speed_value;

  modport source (output valid, output op, output speed_value, input ready);
  modport sink   (input valid, input op, input speed_value, output ready);
endinterface

interface sps_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_pattern;
  logic       stepped;
  logic [1:0] phase_now;
  logic [1:0] turn_direction;

  modport source (output valid, output coil_pattern, output stepped,
                  output phase_now, output turn_direction, input ready);
  modport sink   (input valid, input coil_pattern, input stepped,
                  input phase_now, input turn_direction, output ready);
endinterface
`default_nettype wire

### design/sps_ctrl.sv
// Controller state machine that sequences each command word through the datapath.
`default_nettype none
module sps_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  sps_pkg::status_t     status,
  output sps_pkg::cmd_t        cmd
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DECODE   = 7'b0000010,
    ST_TICK_SUB = 7'b0000100,
    ST_MUL      = 7'b0001000,
    ST_DIV      = 7'b0010000,
    ST_WB       = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.op)
          sps_pkg::OP_TICK: begin
            cmd.tick_add = 1'b1;
            state_next   = ST_TICK_SUB;
          end
          sps_pkg::OP_RPM: begin
            cmd.set_dir = 1'b1;
            if (status.rpm_skip) begin
              state_next = ST_DONE;
            end else begin
              cmd.mul    = 1'b1;
              state_next = ST_MUL;
            end
          end
          sps_pkg::OP_PCT: begin
            cmd.set_dir = 1'b1;
            cmd.set_pct = 1'b1;
            state_next  = ST_DONE;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_TICK_SUB: begin
        cmd.tick_sub = 1'b1;
        state_next   = ST_DONE;
      end
      ST_MUL: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        cmd.period_wr = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register can take a word
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/sps_datapath.sv
// Datapath: config registers, timing accumulator, phase, divider and result register.
`default_nettype none
module sps_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic                            wr_index,
  input  wire logic [sps_pkg::CfgWidth-1:0]    wr_data,
  input  wire logic [1:0]                      in_op,
  input  wire logic signed [15:0]              in_speed,
  input  sps_pkg::cmd_t                        cmd,
  output sps_pkg::status_t                     status,
  sps_out_if.source                            out_ch
);

  logic [sps_pkg::CfgWidth-1:0]    steps_per_rev;
  logic [sps_pkg::CfgWidth-1:0]    tick_increment;
  logic [sps_pkg::PeriodWidth-1:0] step_period;
  logic [sps_pkg::TimeWidth-1:0]   elapsed_time;
  sps_pkg::dir_t                   motion_dir;
  logic [1:0]                      phase;
  logic                            stepped;

  sps_pkg::op_t                    op_q;
  logic [15:0]                     speed_q;

  logic [sps_pkg::ProdWidth-1:0]   product;
  logic [sps_pkg::ProdWidth-1:0]   rem;
  logic [sps_pkg::PeriodWidth-1:0] quo;
  logic [sps_pkg::CountWidth-1:0]  div_count;

  logic                            out_valid;

  logic [15:0]                     mag;
  logic [6:0]                      pct_mag;
  logic [sps_pkg::PeriodWidth-1:0] pct_period;
  sps_pkg::dir_t                   new_dir;
  logic [sps_pkg::TimeWidth:0]     sum;
  logic [sps_pkg::ProdWidth:0]     rem_shift;
  logic                            fits;

  // magnitude of the two's complement value; the most negative value maps to 0x8000
  assign mag     = speed_q[15] ? (~speed_q + 16'd1) : speed_q;
  assign pct_mag = (mag > sps_pkg::PCT_FULL) ? 7'(sps_pkg::PCT_FULL) : mag[6:0];
  assign pct_period = sps_pkg::SLOW_PERIOD
                      - sps_pkg::PeriodWidth'(pct_mag * 12'(sps_pkg::PctStep));

  always_comb begin
    if (speed_q == 16'd0) begin
      new_dir = sps_pkg::DIR_STOP;
    end else if (speed_q[15]) begin
      new_dir = sps_pkg::DIR_CCW;
    end else begin
      new_dir = sps_pkg::DIR_CW;
    end
  end

  assign sum       = {1'b0, elapsed_time} + {17'd0, tick_increment};
  assign rem_shift = {rem, quo[sps_pkg::PeriodWidth-1]};
  assign fits      = (rem_shift >= {1'b0, product});

  assign status.op       = op_q;
  assign status.rpm_skip = (mag == 16'd0) || (steps_per_rev == '0);
  assign status.div_last = (div_count == sps_pkg::CountWidth'(sps_pkg::DivSteps - 1));
  assign status.out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev  <= sps_pkg::STEPS_PER_REV_RST;
      tick_increment <= sps_pkg::TICK_INCREMENT_RST;
    end else if (wr_en) begin
      unique case (sps_pkg::reg_idx_t'(wr_index))
        sps_pkg::REG_STEPS_PER_REV:  steps_per_rev  <= wr_data;
        sps_pkg::REG_TICK_INCREMENT: tick_increment <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period  <= sps_pkg::SLOW_PERIOD;
      elapsed_time <= '0;
      motion_dir   <= sps_pkg::DIR_STOP;
      phase        <= 2'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.tick_add) begin
        // saturate on carry out
        elapsed_time <= sum[sps_pkg::TimeWidth] ? '1 : sum[sps_pkg::TimeWidth-1:0];
      end
      if (cmd.tick_sub && (elapsed_time >= {6'd0, step_period})) begin
        elapsed_time <= elapsed_time - {6'd0, step_period};
        if (motion_dir == sps_pkg::DIR_CW) begin
          phase <= phase + 2'd1;
        end else if (motion_dir == sps_pkg::DIR_CCW) begin
          phase <= phase - 2'd1;
        end
      end
      if (cmd.set_dir) begin
        motion_dir <= new_dir;
      end
      if (cmd.set_pct) begin
        step_period <= pct_period;
      end
      if (cmd.period_wr) begin
        step_period <= quo;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= sps_pkg::op_t'(in_op);
      speed_q <= in_speed;
      stepped <= 1'b0;
    end
    if (cmd.tick_sub) begin
      stepped <= (elapsed_time >= {6'd0, step_period})
                 && (motion_dir != sps_pkg::DIR_STOP);
    end
    if (cmd.mul) begin
      product <= sps_pkg::ProdWidth'({16'd0, steps_per_rev} * {16'd0, mag});
    end
    // restoring divide: 60e6 / (steps_per_rev * |rpm|), one quotient bit a cycle
    if (cmd.div_init) begin
      rem       <= '0;
      quo       <= sps_pkg::US_PER_MINUTE;
      div_count <= '0;
    end
    if (cmd.div_step) begin
      rem       <= fits ? sps_pkg::ProdWidth'(rem_shift - {1'b0, product})
                        : rem_shift[sps_pkg::ProdWidth-1:0];
      quo       <= {quo[sps_pkg::PeriodWidth-2:0], fits};
      div_count <= div_count + sps_pkg::CountWidth'(1);
    end
    if (cmd.out_load) begin
      out_ch.coil_pattern   <= sps_pkg::coil_of(phase);
      out_ch.stepped        <= stepped;
      out_ch.phase_now      <= phase;
      out_ch.turn_direction <= motion_dir;
    end
  end

  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ch.ready))
    else $error("result word overwritten before it was taken");

  a_phase_moves_on_tick: assert property (@(posedge clk) disable iff (rst)
    (phase != $past(phase)) |-> $past(cmd.tick_sub))
    else $error("phase changed outside a tick");

  a_step_needs_motion: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.stepped) |-> (out_ch.turn_direction != sps_pkg::DIR_STOP))
    else $error("step reported while stationary");
`endif

endmodule
`default_nettype wire

### design/stepper_phase_sequencer.sv
// Top level of the four-phase full-step stepper sequencer.
// Each command word yields one result word showing the coil pattern, phase and direction
// after the command. The block works on one command at a time. From one acceptance to the
// next, a tick passes decode and add, compare-subtract, load and accept; a percent command
// passes decode, load and accept; an rpm command adds a registered multiply, the restoring
// divider that forms 60000000 / (steps_per_rev * |rpm|) one quotient bit per cycle, and
// write-back before load. The result word becomes valid in the same cycle that the next
// command can be taken. A result word waits in its own register, so a new command is taken
// while the previous result is still held; the block stalls only when a second result is
// ready before the first was taken. Configuration writes take effect on the next cycle.
`default_nettype none
module stepper_phase_sequencer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic                         wr_index,
  input  wire logic [sps_pkg::CfgWidth-1:0] wr_data,
  sps_in_if.sink                            in_ch,
  sps_out_if.source                         out_ch
);

  sps_pkg::cmd_t    cmd;
  sps_pkg::status_t status;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  sps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sps_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_op    (in_ch.op),
    .in_speed (in_ch.speed_value),
    .cmd      (cmd),
    .status   (status),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

### test/stepper_phase_sequencer_tb.sv
// Self-checking testbench for the stepper phase sequencer: directed and random command words.
`timescale 1ns / 1ps
module stepper_phase_sequencer_tb;
  import sps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [3:0] COIL_BY_PHASE [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

  typedef struct packed {
    logic [3:0] coil;
    logic       stepped;
    logic [1:0] phase;
    dir_t       dir;
  } coil_word_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic wr_index;
  logic [CfgWidth-1:0] wr_data;

  sps_in_if  cmd_ch ();
  sps_out_if res_ch ();

  stepper_phase_sequencer i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (cmd_ch),
    .out_ch   (res_ch)
  );

  // Motor model state and its copy of the registers
  logic [15:0]          model_steps_per_rev;
  logic [15:0]          model_tick_inc;
  logic [PeriodWidth-1:0] model_period;
  logic [TimeWidth-1:0] model_elapsed;
  dir_t                 model_dir;
  logic [1:0]           model_phase;

  coil_word_t coil_fifo [$];
  coil_word_t want_word;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          fail_count;
  int unsigned cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stepper_phase_sequencer_tb: FAIL");
      $finish;
    end
  end

  // Apply one command word to the motor model and form the result word it yields.
  function automatic coil_word_t advance_motor(input op_t op, input logic [15:0] speed);
    coil_word_t  word;
    logic [16:0] mag;
    logic [32:0] sum;
    int unsigned quot;
    logic        did_step;
    did_step = 1'b0;
    mag = speed[15] ? (17'h10000 - {1'b0, speed}) : {1'b0, speed};
    case (op)
      OP_TICK: begin
        sum = {1'b0, model_elapsed} + {17'd0, model_tick_inc};
        model_elapsed = sum[32] ? '1 : sum[31:0];
        if (model_elapsed >= {6'd0, model_period}) begin
          model_elapsed = model_elapsed - {6'd0, model_period};
          if (model_dir == DIR_CW) begin
            model_phase = model_phase + 2'd1;
            did_step = 1'b1;
          end else if (model_dir == DIR_CCW) begin
            model_phase = model_phase - 2'd1;
            did_step = 1'b1;
          end
        end
      end
      OP_RPM, OP_PCT: begin
        if (op == OP_RPM) begin
          // hold the period on zero speed or zero steps per revolution
          if (mag != 0 && model_steps_per_rev != 0) begin
            quot = 32'd60000000 / {16'd0, model_steps_per_rev};
            quot = quot / {15'd0, mag};
            model_period = quot[PeriodWidth-1:0];
          end
        end else begin
          if (mag > 17'd100) mag = 17'd100;
          model_period = 26'd4000 - ({9'd0, mag} * 26'd2500) / 26'd100;
        end
        if (speed == 16'd0) model_dir = DIR_STOP;
        else if (speed[15]) model_dir = DIR_CCW;
        else model_dir = DIR_CW;
      end
      default: ;
    endcase
    word.coil    = COIL_BY_PHASE[model_phase];
    word.stepped = did_step;
    word.phase   = model_phase;
    word.dir     = model_dir;
    return word;
  endfunction

  task automatic send_cmd(input op_t op, input logic [15:0] speed);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid       <= 1'b0;
      cmd_ch.op          <= 2'($urandom);
      cmd_ch.speed_value <= 16'($urandom);
      @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.op          <= op;
    cmd_ch.speed_value <= speed;
    do @(posedge clk); while (!cmd_ch.ready);
    coil_fifo.push_back(advance_motor(op, speed));
    @(negedge clk);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (coil_fifo.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CfgWidth-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    if (idx == REG_STEPS_PER_REV) model_steps_per_rev = value;
    else model_tick_inc = value;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure_motor(input logic [15:0] spr, input logic [15:0] inc);
    drain_results();
    write_reg(REG_STEPS_PER_REV, spr);
    write_reg(REG_TICK_INCREMENT, inc);
  endtask

  task automatic test_reset_state();
    send_cmd(OP_NONE, 16'h1234);
    send_cmd(OP_TICK, 16'hFFFF);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_PCT, 16'd0);
  endtask

  task automatic test_speed_commands();
    send_cmd(OP_PCT, 16'd100);
    repeat (4) send_cmd(OP_TICK, 16'($urandom));
    send_cmd(OP_PCT, -16'sd100);
    repeat (2) send_cmd(OP_TICK, 16'($urandom));
    send_cmd(OP_PCT, 16'd101);
    send_cmd(OP_PCT, 16'h8000);
    send_cmd(OP_PCT, 16'h7FFF);
    send_cmd(OP_RPM, 16'd0);
    send_cmd(OP_TICK, 16'd0);
    send_cmd(OP_RPM, 16'd15);
    send_cmd(OP_RPM, 16'hFFFF);
    send_cmd(OP_RPM, 16'h7FFF);
    send_cmd(OP_NONE, 16'hFFFF);
  endtask

  task automatic test_register_extremes();
    configure_motor(16'd0, 16'd500);
    send_cmd(OP_RPM, 16'd5);
    // 60000000 / 65535 / 32768 rounds to a zero period: step on every tick
    configure_motor(16'hFFFF, 16'hFFFF);
    send_cmd(OP_RPM, 16'h8000);
    repeat (2) send_cmd(OP_TICK, 16'($urandom));
    configure_motor(16'd1, 16'd1);
    send_cmd(OP_RPM, 16'd1);
    send_cmd(OP_TICK, 16'($urandom));
  endtask

  task automatic send_random_cmd();
    int          pick;
    logic [15:0] speed;
    pick = $urandom_range(99);
    if (pick < 58) begin
      send_cmd(OP_TICK, 16'($urandom));
    end else if (pick < 76) begin
      if ($urandom_range(3) == 0) speed = 16'($urandom);
      else speed = 16'($urandom_range(240)) - 16'd120;
      send_cmd(OP_PCT, speed);
    end else if (pick < 95) begin
      if ($urandom_range(3) == 0) speed = 16'($urandom);
      else speed = 16'($urandom_range(160)) - 16'd80;
      send_cmd(OP_RPM, speed);
    end else begin
      send_cmd(OP_NONE, 16'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct,
                                     input logic [15:0] spr, input logic [15:0] inc);
    configure_motor(spr, inc);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_random_cmd();
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (coil_fifo.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want_word = coil_fifo.pop_front();
        if (res_ch.coil_pattern !== want_word.coil) begin
          $error("coil_pattern: expected %h, got %h", want_word.coil, res_ch.coil_pattern);
          fail_count++;
        end
        if (res_ch.stepped !== want_word.stepped) begin
          $error("stepped: expected %b, got %b", want_word.stepped, res_ch.stepped);
          fail_count++;
        end
        if (res_ch.phase_now !== want_word.phase) begin
          $error("phase_now: expected %0d, got %0d", want_word.phase, res_ch.phase_now);
          fail_count++;
        end
        if (res_ch.turn_direction !== want_word.dir) begin
          $error("turn_direction: expected %0d, got %0d", want_word.dir,
                 res_ch.turn_direction);
          fail_count++;
        end
      end
    end
  end

  // Receiver: stall at the configured rate
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = 1'b0;
    wr_data            = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.op          = OP_TICK;
    cmd_ch.speed_value = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    fail_count         = 0;
    cycle_count        = 0;

    model_steps_per_rev = STEPS_PER_REV_RST;
    model_tick_inc      = TICK_INCREMENT_RST;
    model_period        = SLOW_PERIOD;
    model_elapsed       = '0;
    model_dir           = DIR_STOP;
    model_phase         = 2'd0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_speed_commands();
    test_register_extremes();

    test_random_traffic(300, 0, 0, 16'd2048, 16'd500);
    test_random_traffic(250, 64, 0, 16'($urandom_range(4096, 1)),
                        16'($urandom_range(2000, 200)));
    test_random_traffic(250, 0, 64, 16'hFFFF, 16'hFFFF);
    test_random_traffic(250, 34, 34, 16'd1, 16'hFFFF);
    test_random_traffic(200, 0, 0, 16'($urandom), 16'($urandom));
    test_random_traffic(200, 34, 34, 16'd2048, 16'd1);

    drain_results();
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("stepper_phase_sequencer_tb: PASS");
    end else begin
      $display("stepper_phase_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
